### hw/rtl/fir_pkg.sv
// ----------------------------------------------------------------------------
// fir_pkg: shared types and constants for the direct-form FIR filter
// Field widths, opcodes, register indexes, request/response structs and the per-cell control struct.
// ----------------------------------------------------------------------------
package fir_pkg;

   localparam int MAX_TAPS    = 128;
   localparam int SAMPLE_BITS = 16;
   localparam int COEFF_BITS  = 16;
   localparam int ACC_BITS    = 40;
   localparam int IDX_BITS    = 7;
   localparam int PROD_BITS   = SAMPLE_BITS + COEFF_BITS;
   localparam int CNT_W       = $clog2(MAX_TAPS);

   localparam int TAP_COUNT_BITS    = 8;
   localparam int OUTPUT_SHIFT_BITS = 5;
   localparam int CSR_DATA_BITS     = 8;
   localparam int CSR_INDEX_BITS    = 1;

   localparam int TAP_COUNT_RESET    = 80;
   localparam int OUTPUT_SHIFT_RESET = 15;

   // opcodes
   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_LOAD   = 1'b1;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAP_COUNT    = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OUTPUT_SHIFT = 1'b1;

   typedef struct packed {
      logic                          opcode;
      logic [IDX_BITS-1:0]           coeff_index;
      logic signed [COEFF_BITS-1:0]  coeff_value;
      logic signed [SAMPLE_BITS-1:0] sample;
   } fir_req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] filtered;
      logic                          saturated;
   } fir_rsp_type;

   // control broadcast to every cell of the ring
   typedef struct packed {
      logic shift_in;  // new sample enters, history moves one cell older
      logic rotate;    // whole ring moves one cell toward cell 0
   } fir_cell_ctrl_type;

endpackage

### hw/rtl/fir_filter_mac.sv
// ----------------------------------------------------------------------------
// fir_filter_mac: direct-form FIR filter, Q1.15 samples and coefficients
//
// req_ channel (valid/ready) carries one transaction per item. A load
// transaction (opcode load) writes coeff_value into tap coeff_index;
// it produces no response. A filter transaction pushes the
// sample into the history ring, then one MAC walks all MAX_TAPS cells while
// the ring rotates once, summing the first tap_count products in 40 bits.
// The sum is shifted right by output_shift, saturated to 16 bits and
// returned on the rsp_ channel with the saturated flag.
// The response is registered in DONE, after the RUN pass and DRAIN. A
// filter transaction holds req_ready low through RUN, DRAIN and DONE, set
// by the single MAC and the full ring rotation; loads go one per cycle
// while idle. The response sits in an output register; new requests are
// taken while it waits. If rsp_ready stays low, the next result holds in
// the MAC until the register frees, and req_ready stays low meanwhile.
// csr_ writes (tap_count, output_shift) must only be issued while idle.
// Reset (synchronous) clears history, taps, pass counter and registers:
// tap_count 80, output_shift 15.
// ----------------------------------------------------------------------------
module fir_filter_mac
   import fir_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  fir_req_type               req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output fir_rsp_type               rsp_data,
   input  logic                      csr_we,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_RUN   = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_TAPS - 1);

   state_type                      state_ff, state_in;
   logic [CNT_W-1:0]               count_ff, count_in;
   logic [TAP_COUNT_BITS-1:0]      tap_count_ff, tap_count_in;
   logic [OUTPUT_SHIFT_BITS-1:0]   output_shift_ff, output_shift_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   fir_rsp_type                    rsp_data_ff, rsp_data_in;

   logic                           req_accept;
   logic                           rsp_write;
   fir_cell_ctrl_type              cell_ctrl;
   logic signed [SAMPLE_BITS-1:0]  hist_w  [MAX_TAPS];
   logic signed [COEFF_BITS-1:0]   coeff_w [MAX_TAPS];
   logic signed [ACC_BITS-1:0]     acc;
   logic signed [ACC_BITS-1:0]     shifted;
   logic                           sat;
   logic                           mac_clear;
   logic                           mac_step;
   logic                           tap_used;

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;

   always_comb begin
      cell_ctrl.shift_in = req_accept && (req_data.opcode == OP_FILTER);
      cell_ctrl.rotate   = (state_ff == ST_RUN);
   end

   // ring of cells: cell k holds the sample k items old and coefficient k
   // while idle; during a pass cell 0 presents pair j while the count is j
   for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
      logic load_sel;
      assign load_sel = req_accept && (req_data.opcode == OP_LOAD)
                        && (int'(req_data.coeff_index) == k);
      fir_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .load_en    (load_sel),
         .load_value (req_data.coeff_value),
         .prev_hist  ((k == 0) ? req_data.sample : hist_w[(k + MAX_TAPS - 1) % MAX_TAPS]),
         .next_hist  (hist_w[(k + 1) % MAX_TAPS]),
         .next_coeff (coeff_w[(k + 1) % MAX_TAPS]),
         .hist       (hist_w[k]),
         .coeff      (coeff_w[k])
      );
   end

   assign mac_clear = cell_ctrl.shift_in;
   assign mac_step  = (state_ff == ST_RUN);
   assign tap_used  = int'(count_ff) < int'(tap_count_ff);

   fir_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .clear    (mac_clear),
      .step     (mac_step),
      .tap_used (tap_used),
      .coeff    (coeff_w[0]),
      .hist     (hist_w[0]),
      .acc      (acc)
   );

   // arithmetic shift (floor), then saturate to SAMPLE_BITS
   always_comb begin
      shifted = acc >>> output_shift_ff;
      sat     = !((&shifted[ACC_BITS-1:SAMPLE_BITS-1])
                  || !(|shifted[ACC_BITS-1:SAMPLE_BITS-1]));
      rsp_data_in.saturated = sat;
      if (!sat) begin
         rsp_data_in.filtered = shifted[SAMPLE_BITS-1:0];
      end else if (shifted[ACC_BITS-1]) begin
         rsp_data_in.filtered = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         rsp_data_in.filtered = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

   assign rsp_write = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      unique case (state_ff)
         ST_IDLE: begin
            count_in = '0;
            if (cell_ctrl.shift_in) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            count_in = count_ff + 1'b1;
            if (count_ff == LAST_CNT) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_write) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (rsp_write) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      tap_count_in    = tap_count_ff;
      output_shift_in = output_shift_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_TAP_COUNT:    tap_count_in    = csr_wdata[TAP_COUNT_BITS-1:0];
            CSR_OUTPUT_SHIFT: output_shift_in = csr_wdata[OUTPUT_SHIFT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
         tap_count_ff    <= TAP_COUNT_BITS'(TAP_COUNT_RESET);
         output_shift_ff <= OUTPUT_SHIFT_BITS'(OUTPUT_SHIFT_RESET);
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         rsp_valid_ff    <= rsp_valid_in;
         tap_count_ff    <= tap_count_in;
         output_shift_ff <= output_shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_write) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a filter transaction starts a pass; a load leaves the block idle
   a_filter_starts_pass: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.opcode == OP_FILTER) |=> (state_ff == ST_RUN))
      else $error("filter transaction did not start a pass");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.opcode == OP_LOAD) |=> (state_ff == ST_IDLE))
      else $error("load transaction left idle");

   // a pass lasts until the counter reaches the last cell
   a_run_full_ring: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && count_ff != LAST_CNT) |=> (state_ff == ST_RUN))
      else $error("pass ended before a full rotation");

   // a fresh response only comes out of the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside done state");

endmodule

### hw/rtl/fir_cell.sv
// ----------------------------------------------------------------------------
// fir_cell: one tap of the filter ring
// Holds one history sample and one coefficient; shifts samples in, rotates
// both toward cell 0 during a pass, and takes coefficient loads.
// ----------------------------------------------------------------------------
module fir_cell
   import fir_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  fir_cell_ctrl_type             ctrl,
   input  logic                          load_en,
   input  logic signed [COEFF_BITS-1:0]  load_value,
   input  logic signed [SAMPLE_BITS-1:0] prev_hist,
   input  logic signed [SAMPLE_BITS-1:0] next_hist,
   input  logic signed [COEFF_BITS-1:0]  next_coeff,
   output logic signed [SAMPLE_BITS-1:0] hist,
   output logic signed [COEFF_BITS-1:0]  coeff
);

   logic signed [SAMPLE_BITS-1:0] hist_ff, hist_in;
   logic signed [COEFF_BITS-1:0]  coeff_ff, coeff_in;

   always_comb begin
      hist_in  = hist_ff;
      coeff_in = coeff_ff;
      priority if (load_en) begin
         coeff_in = load_value;
      end else if (ctrl.shift_in) begin
         hist_in = prev_hist;
      end else if (ctrl.rotate) begin
         hist_in  = next_hist;
         coeff_in = next_coeff;
      end else begin
         hist_in  = hist_ff;
         coeff_in = coeff_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff  <= '0;
         coeff_ff <= '0;
      end else begin
         hist_ff  <= hist_in;
         coeff_ff <= coeff_in;
      end
   end

   assign hist  = hist_ff;
   assign coeff = coeff_ff;

endmodule

### hw/rtl/fir_mac.sv
// ----------------------------------------------------------------------------
// fir_mac: shared multiply-accumulate
// Registered 16x16 product, then a 40-bit wrapping accumulator.
// ----------------------------------------------------------------------------
module fir_mac
   import fir_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic                          step,
   input  logic                          tap_used,
   input  logic signed [COEFF_BITS-1:0]  coeff,
   input  logic signed [SAMPLE_BITS-1:0] hist,
   output logic signed [ACC_BITS-1:0]    acc
);

   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic                        prod_en_ff, prod_en_in;
   logic signed [ACC_BITS-1:0]  acc_ff, acc_in;

   always_comb begin
      prod_in    = PROD_BITS'(coeff * hist);
      prod_en_in = step && tap_used && !clear;
      if (clear) begin
         acc_in = '0;
      end else if (prod_en_ff) begin
         acc_in = acc_ff + ACC_BITS'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_en_ff <= 1'b0;
         acc_ff     <= '0;
      end else begin
         prod_en_ff <= prod_en_in;
         acc_ff     <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign acc = acc_ff;

endmodule

### tb/sv/fir_filter_mac_tb.sv
// ----------------------------------------------------------------------------
// fir_filter_mac_tb: self-checking testbench for the fixed-point FIR filter
// Drives coefficient loads and filter samples on req_ with random gaps, and
// stalls rsp_ at random. A tracker predicts each filtered output from its own
// copy of the tap table and sample history. Tap count and output shift are
// swept between phases, including zero taps and counts beyond the table.
// ----------------------------------------------------------------------------
module fir_filter_mac_tb;
   import fir_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   fir_req_type               req_data  = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   fir_rsp_type               rsp_data;
   logic                      csr_we    = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // when set, the sender leaves no gaps and rsp_ready stays high once any long stall has run out
   bit steady_flow = 1'b0;

   class fir_output_tracker;
      logic signed [SAMPLE_BITS-1:0] history_mem [MAX_TAPS];
      logic signed [COEFF_BITS-1:0]  coeff_mem   [MAX_TAPS];
      logic [IDX_BITS-1:0]           newest_slot;
      logic [TAP_COUNT_BITS-1:0]     tap_count;
      logic [OUTPUT_SHIFT_BITS-1:0]  output_shift;
      fir_rsp_type                   pending_outputs [$];
      int                            error_count;

      function new();
         foreach (history_mem[i]) begin
            history_mem[i] = '0;
            coeff_mem[i]   = '0;
         end
         newest_slot  = '0;
         tap_count    = TAP_COUNT_RESET;
         output_shift = OUTPUT_SHIFT_RESET;
         error_count  = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] value);
         if (index == CSR_TAP_COUNT) begin
            tap_count = value[TAP_COUNT_BITS-1:0];
         end else begin
            output_shift = value[OUTPUT_SHIFT_BITS-1:0];
         end
      endfunction

      function void accept_item(fir_req_type item);
         logic signed [ACC_BITS-1:0] acc;
         logic signed [ACC_BITS-1:0] scaled;
         logic [IDX_BITS-1:0]        slot;
         int                         used_taps;
         fir_rsp_type                result;
         if (item.opcode == OP_LOAD) begin
            coeff_mem[item.coeff_index] = item.coeff_value;
            return;
         end
         history_mem[newest_slot] = item.sample;
         used_taps = (tap_count > MAX_TAPS) ? MAX_TAPS : int'(tap_count);
         acc = '0;
         for (int k = 0; k < used_taps; k++) begin
            slot = newest_slot - IDX_BITS'(k);
            acc  = acc + coeff_mem[k] * history_mem[slot];
         end
         scaled = acc >>> output_shift;
         if (scaled > 40'sd32767) begin
            result.filtered  = 16'sh7fff;
            result.saturated = 1'b1;
         end else if (scaled < -40'sd32768) begin
            result.filtered  = 16'sh8000;
            result.saturated = 1'b1;
         end else begin
            result.filtered  = scaled[SAMPLE_BITS-1:0];
            result.saturated = 1'b0;
         end
         pending_outputs.push_back(result);
         newest_slot = newest_slot + 1'b1;
      endfunction

      function void check_output(fir_rsp_type actual);
         fir_rsp_type wanted;
         if (pending_outputs.size() == 0) begin
            $error("unexpected output: filtered %0d saturated %0b",
                   actual.filtered, actual.saturated);
            error_count++;
            return;
         end
         wanted = pending_outputs.pop_front();
         if (actual.filtered !== wanted.filtered) begin
            $error("filtered: expected %0d, actual %0d", wanted.filtered, actual.filtered);
            error_count++;
         end
         if (actual.saturated !== wanted.saturated) begin
            $error("saturated: expected %0b, actual %0b",
                   wanted.saturated, actual.saturated);
            error_count++;
         end
      endfunction
   endclass

   fir_output_tracker tracker;

   fir_filter_mac uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #80ms;
      $display("tb: failure");
      $finish;
   end

   // transaction monitor: values read here are the ones before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) tracker.check_output(rsp_data);
         if (req_valid && req_ready) tracker.accept_item(req_data);
      end
   end

   // output side backpressure, with an occasional long stall
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            hold--;
         end else if (steady_flow) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 17);
            if ($urandom_range(499) == 0) hold = $urandom_range(150, 300);
         end
      end
   end

   function automatic int sender_gap();
      if (steady_flow || $urandom_range(99) >= 17) return 0;
      // mostly short gaps; a few long ones land anywhere in a filter pass
      if ($urandom_range(49) == 0) return $urandom_range(20, 140);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic signed [15:0] pick_q15();
      case ($urandom_range(9))
         0:       return 16'sh7fff;
         1:       return 16'sh8000;
         2:       return 16'($urandom_range(0, 511) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic fir_req_type make_item(logic op, int idx, int coeff, int smp);
      fir_req_type item;
      item.opcode      = op;
      item.coeff_index = IDX_BITS'(idx);
      item.coeff_value = COEFF_BITS'(coeff);
      item.sample      = SAMPLE_BITS'(smp);
      return item;
   endfunction

   function automatic fir_req_type random_item();
      fir_req_type item;
      item.opcode      = ($urandom_range(99) < 30) ? OP_LOAD : OP_FILTER;
      item.coeff_index = $urandom_range(1) ? IDX_BITS'($urandom_range(0, 15))
                                           : IDX_BITS'($urandom);
      item.coeff_value = pick_q15();
      item.sample      = pick_q15();
      return item;
   endfunction

   // valid stays high across back-to-back transactions
   task automatic send_item(input fir_req_type item);
      int gap;
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   // one edge first so the monitor has logged the last accepted transaction
   task automatic drain_outputs();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending_outputs.size() != 0) @(posedge clock);
      repeat (MAX_TAPS + 8) @(posedge clock);
   endtask

   task automatic write_registers(input logic [CSR_DATA_BITS-1:0] taps,
                                  input logic [CSR_DATA_BITS-1:0] shift_word);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_TAP_COUNT;
      csr_wdata <= taps;
      @(posedge clock);
      csr_index <= CSR_OUTPUT_SHIFT;
      csr_wdata <= shift_word;
      @(posedge clock);
      csr_we <= 1'b0;
      tracker.set_register(CSR_TAP_COUNT, taps);
      tracker.set_register(CSR_OUTPUT_SHIFT, shift_word);
   endtask

   initial begin
      // -1 picks a random legal value
      int             phase_taps  [8] = '{128, 1, 0, 255, 129, -1, -1, 128};
      int             phase_shift [8] = '{0, 31, 15, 7, 31, -1, -1, 31};
      fir_req_type    directed [$];
      logic [7:0]     taps;
      logic [7:0]     shift_word;

      tracker = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty tap table gives zero regardless of sample
      directed.push_back(make_item(OP_FILTER, 99, -5, 32767));
      directed.push_back(make_item(OP_FILTER, 7, 1234, -32768));
      directed.push_back(make_item(OP_LOAD, 0, 32767, -1));
      directed.push_back(make_item(OP_LOAD, 1, -32768, 32767));
      directed.push_back(make_item(OP_LOAD, 2, -1, 0));
      directed.push_back(make_item(OP_LOAD, 127, -32768, 12));
      directed.push_back(make_item(OP_LOAD, 64, 16384, -7));
      directed.push_back(make_item(OP_LOAD, 79, 32767, 3));
      directed.push_back(make_item(OP_FILTER, 127, 32767, 32767));
      directed.push_back(make_item(OP_FILTER, 0, -32768, -32768));
      directed.push_back(make_item(OP_FILTER, 5, 100, 0));
      directed.push_back(make_item(OP_FILTER, 0, 0, -1));
      directed.push_back(make_item(OP_FILTER, 0, 0, 1));
      directed.push_back(make_item(OP_LOAD, 0, -32768, 0));
      directed.push_back(make_item(OP_LOAD, 1, -32768, 0));
      directed.push_back(make_item(OP_FILTER, 0, 0, 32767));
      directed.push_back(make_item(OP_FILTER, 0, 0, 32767));
      directed.push_back(make_item(OP_FILTER, 0, 0, -32768));
      directed.push_back(make_item(OP_FILTER, 0, 0, -32768));
      foreach (directed[i]) send_item(directed[i]);

      // reset configuration first, then one phase per register setting
      repeat (200) send_item(random_item());
      for (int p = 0; p < 8; p++) begin
         drain_outputs();
         taps = (phase_taps[p] < 0) ? 8'($urandom_range(1, 128)) : 8'(phase_taps[p]);
         shift_word = (phase_shift[p] < 0) ? 8'($urandom)
                                           : {3'($urandom), 5'(phase_shift[p])};
         write_registers(taps, shift_word);
         steady_flow = (p == 2);
         repeat (200) send_item(random_item());
      end
      steady_flow = 1'b0;

      drain_outputs();
      if (tracker.pending_outputs.size() != 0) begin
         $error("%0d outputs never arrived", tracker.pending_outputs.size());
         tracker.error_count++;
      end
      if (tracker.error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/fir_pkg.sv
hw/rtl/fir_cell.sv
hw/rtl/fir_mac.sv
hw/rtl/fir_filter_mac.sv
tb/sv/fir_filter_mac_tb.sv
